// ===== hdl/ecal_pkg.sv =====
`default_nettype none

package ecal_pkg;

	// pipeline depth from input register to output register
	localparam int unsigned NSTG = 14;
	localparam int unsigned OCC_W = $clog2(NSTG + 1);

	// seconds to days: shift out 2^7, then divide by the odd part 675
	localparam int unsigned DIV_D = 675;
	localparam int unsigned HI_BIAS = 1554;
	localparam int unsigned HI_OFF = HI_BIAS * DIV_D;

	// reciprocal for the high chunk (22-bit dividend) and the low chunk (30-bit)
	localparam int unsigned S_H = 32;
	localparam logic [22:0] M_H = 23'(((64'd1 << S_H) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));
	localparam int unsigned S_X = 40;
	localparam logic [30:0] M_X = 31'(((64'd1 << S_X) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));

	// era split, with a bias that keeps the shifted day count non-negative
	localparam int unsigned ERA_DAYS = 146097;
	localparam int unsigned ERA_BIAS = 11145;
	localparam int unsigned DAY_SHIFT = 719468;
	localparam logic [31:0] W_SUB = 32'((64'(HI_BIAS) << 20) - 64'(DAY_SHIFT)
		- 64'(ERA_BIAS) * 64'(ERA_DAYS));
	localparam int unsigned S_E = 49;
	localparam logic [31:0] M_E = 32'((64'd1 << S_E) / 64'(ERA_DAYS));

	// exact round-up reciprocals for the narrow divisions
	localparam int unsigned S_A = 29;
	localparam logic [18:0] M_A = 19'(((64'd1 << S_A) + 64'd1459) / 64'd1460);
	localparam int unsigned S_W = 21;
	localparam logic [18:0] M_W = 19'(((64'd1 << S_W) + 64'd6) / 64'd7);
	localparam int unsigned S_Y = 27;
	localparam logic [18:0] M_Y = 19'(((64'd1 << S_Y) + 64'd364) / 64'd365);
	localparam int unsigned S_MP = 19;
	localparam logic [11:0] M_MP = 12'(((64'd1 << S_MP) + 64'd152) / 64'd153);
	localparam int unsigned S_MT = 23;
	localparam logic [17:0] M_MT = 18'(((64'd1 << S_MT) + 64'd59) / 64'd60);
	localparam int unsigned S_HR = 17;
	localparam logic [11:0] M_HR = 12'(((64'd1 << S_HR) + 64'd59) / 64'd60);

	// quarter-era boundaries within an era, and the last day of an era
	localparam logic [17:0] DOE_Q1 = 18'd36524;
	localparam logic [17:0] DOE_Q2 = 18'd73048;
	localparam logic [17:0] DOE_Q3 = 18'd109572;
	localparam logic [17:0] DOE_LAST = 18'd146096;

	// calendar constants
	localparam logic [8:0] YOE_C1 = 9'd100;
	localparam logic [8:0] YOE_C2 = 9'd200;
	localparam logic [8:0] YOE_C3 = 9'd300;
	localparam logic [23:0] YEAR_SUB = 24'(400 * ERA_BIAS + 1900);
	localparam logic [3:0] MP_JAN = 4'd10;
	localparam logic [8:0] JAN1_DOY = 9'd306;
	localparam logic [8:0] MAR1_YDAY = 9'd59;
	localparam logic [3:0] MONTH_JAN = 4'd0;
	localparam logic [3:0] MONTH_DEC = 4'd11;

	typedef struct packed {
		logic signed [47:0] epoch_seconds;
	} ecal_in_t;

	typedef struct packed {
		logic signed [23:0] year_offset;
		logic [3:0]         month_index;
		logic [4:0]         day_of_month;
		logic [4:0]         hour_of_day;
		logic [5:0]         minute_of_hour;
		logic [5:0]         second_of_minute;
		logic [2:0]         weekday;
		logic [8:0]         day_of_year;
	} ecal_out_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	// first day of each march-based month, (153 * mp + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0: d = 9'd0;
			4'd1: d = 9'd31;
			4'd2: d = 9'd61;
			4'd3: d = 9'd92;
			4'd4: d = 9'd122;
			4'd5: d = 9'd153;
			4'd6: d = 9'd184;
			4'd7: d = 9'd214;
			4'd8: d = 9'd245;
			4'd9: d = 9'd275;
			4'd10: d = 9'd306;
			4'd11: d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ecal_stream_if.sv =====
`default_nettype none

interface ecal_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/epoch_seconds_to_utc_calendar.sv =====
`default_nettype none

// Converts a signed 48-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// proleptic Gregorian date, time of day, weekday (Sunday is 0) and day of year.
// One item is taken every cycle while the output side is ready; each item passes
// through the registers s1 to s14. The stages carry out a chain of constant divisions
// (by 675, by the 400-year era, by 1460, 7, 365, 153 and 60), each done as a registered
// reciprocal multiply, some followed by a registered remainder or correction step.
// Every stage advances on its own, so empty stages close up behind a stalled
// result and input is still taken until the pipeline is full; input ready follows
// output ready combinationally. Reset only clears the stage valid bits.
module epoch_seconds_to_utc_calendar
	import ecal_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	ecal_stream_if.sink    epoch,
	ecal_stream_if.source  calendar
);

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;

	// stage enables: a stage loads when it is empty or the next one moves
	always_comb begin
		en[NSTG+1] = calendar.ready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign epoch.ready = en[1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= epoch.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// s1: split off the low 7 bits, bias the high chunk non-negative
	logic [21:0] h_s1;
	logic [19:0] ul_s1;
	logic [6:0]  t7_s1;
	logic [47:0] t_in;

	assign t_in = epoch.data.epoch_seconds;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			h_s1  <= {t_in[47], t_in[47:27]} + 22'(HI_OFF);
			ul_s1 <= t_in[26:7];
			t7_s1 <= t_in[6:0];
		end
	end

	// s2: high chunk quotient by 675
	logic [44:0] prod_h;
	logic [11:0] qh_s2;
	logic [21:0] h_s2;
	logic [19:0] ul_s2;
	logic [6:0]  t7_s2;

	assign prod_h = 45'(h_s1) * 45'(M_H);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			qh_s2 <= prod_h[S_H +: 12];
			h_s2  <= h_s1;
			ul_s2 <= ul_s1;
			t7_s2 <= t7_s1;
		end
	end

	// s3: high chunk remainder joins the low chunk
	logic [9:0]  rh;
	logic [29:0] x2_s3;
	logic [11:0] qh_s3;
	logic [6:0]  t7_s3;

	assign rh = 10'(h_s2 - 22'(qh_s2) * 22'(DIV_D));

	always_ff @(posedge clk) begin
		if (en[3]) begin
			x2_s3 <= {rh, ul_s2};
			qh_s3 <= qh_s2;
			t7_s3 <= t7_s2;
		end
	end

	// s4: low chunk quotient by 675
	logic [60:0] prod_x;
	logic [19:0] q2_s4;
	logic [29:0] x2_s4;
	logic [11:0] qh_s4;
	logic [6:0]  t7_s4;

	assign prod_x = 61'(x2_s3) * 61'(M_X);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			q2_s4 <= prod_x[S_X +: 20];
			x2_s4 <= x2_s3;
			qh_s4 <= qh_s3;
			t7_s4 <= t7_s3;
		end
	end

	// s5: second of the day, and the biased day count for the era split
	logic [9:0]  r2;
	logic [16:0] secs_s5;
	logic [31:0] w_s5;

	assign r2 = 10'(x2_s4 - 30'(q2_s4) * 30'(DIV_D));

	always_ff @(posedge clk) begin
		if (en[5]) begin
			secs_s5 <= {r2, t7_s4};
			w_s5    <= {qh_s4, q2_s4} - W_SUB;
		end
	end

	// s6: era estimate, minutes of the day
	logic [63:0] prod_e;
	logic [34:0] prod_mt;
	logic [14:0] era0_s6;
	logic [31:0] w_s6;
	logic [10:0] mt_s6;
	logic [16:0] secs_s6;

	assign prod_e  = 64'(w_s5) * 64'(M_E);
	assign prod_mt = 35'(secs_s5) * 35'(M_MT);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			era0_s6 <= prod_e[S_E +: 15];
			w_s6    <= w_s5;
			mt_s6   <= prod_mt[S_MT +: 11];
			secs_s6 <= secs_s5;
		end
	end

	// s7: era remainder before correction, seconds of the minute
	logic [18:0] re_s7;
	logic [14:0] era0_s7;
	logic [10:0] mt_s7;
	logic [5:0]  sec_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			re_s7   <= 19'(w_s6 - 32'(era0_s6) * 32'(ERA_DAYS));
			era0_s7 <= era0_s6;
			mt_s7   <= mt_s6;
			sec_s7  <= 6'(secs_s6 - 17'(mt_s6) * 17'd60);
		end
	end

	// s8: correct the era estimate, hour of the day
	logic        re_over;
	logic [22:0] prod_hr;
	logic [17:0] doe_s8;
	logic [14:0] era_s8;
	logic [4:0]  hr_s8;
	logic [10:0] mt_s8;
	logic [5:0]  sec_s8;

	assign re_over = re_s7 >= 19'(ERA_DAYS);
	assign prod_hr = 23'(mt_s7) * 23'(M_HR);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			doe_s8 <= re_over ? 18'(re_s7 - 19'(ERA_DAYS)) : 18'(re_s7);
			era_s8 <= re_over ? era0_s7 + 15'd1 : era0_s7;
			hr_s8  <= prod_hr[S_HR +: 5];
			mt_s8  <= mt_s7;
			sec_s8 <= sec_s7;
		end
	end

	// s9: doe / 1460 and the weekday quotient, minute of the hour
	logic [17:0] xw_s8;
	logic [36:0] prod_a;
	logic [36:0] prod_w;
	logic [6:0]  a_s9;
	logic [14:0] wq_s9;
	logic [17:0] doe_s9;
	logic [14:0] era_s9;
	tod_t        tod_s9;

	assign xw_s8  = doe_s8 + 18'd3;
	assign prod_a = 37'(doe_s8) * 37'(M_A);
	assign prod_w = 37'(xw_s8) * 37'(M_W);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			a_s9          <= prod_a[S_A +: 7];
			wq_s9         <= prod_w[S_W +: 15];
			doe_s9        <= doe_s8;
			era_s9        <= era_s8;
			tod_s9.hour   <= hr_s8;
			tod_s9.minute <= 6'(mt_s8 - 11'(hr_s8) * 11'd60);
			tod_s9.second <= sec_s8;
		end
	end

	// s10: leap-day corrected numerator for the year of era, weekday
	logic [2:0]  quarters;
	logic        last_day;
	logic [17:0] xw_s9;
	logic [17:0] num_s10;
	logic [2:0]  wd_s10;
	logic [17:0] doe_s10;
	logic [14:0] era_s10;
	tod_t        tod_s10;

	assign quarters = 3'(doe_s9 >= DOE_Q1) + 3'(doe_s9 >= DOE_Q2)
		+ 3'(doe_s9 >= DOE_Q3) + 3'(doe_s9 >= DOE_LAST);
	assign last_day = doe_s9 == DOE_LAST;
	assign xw_s9    = doe_s9 + 18'd3;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			num_s10 <= doe_s9 - 18'(a_s9) + 18'(quarters) - 18'(last_day);
			wd_s10  <= 3'(xw_s9 - 18'(wq_s9) * 18'd7);
			doe_s10 <= doe_s9;
			era_s10 <= era_s9;
			tod_s10 <= tod_s9;
		end
	end

	// s11: year of era
	logic [36:0] prod_y;
	logic [8:0]  yoe_s11;
	logic [17:0] doe_s11;
	logic [14:0] era_s11;
	logic [2:0]  wd_s11;
	tod_t        tod_s11;

	assign prod_y = 37'(num_s10) * 37'(M_Y);

	always_ff @(posedge clk) begin
		if (en[11]) begin
			yoe_s11 <= prod_y[S_Y +: 9];
			doe_s11 <= doe_s10;
			era_s11 <= era_s10;
			wd_s11  <= wd_s10;
			tod_s11 <= tod_s10;
		end
	end

	// s12: day of the march-based year, leap flag, biased year
	logic        yc1;
	logic        yc2;
	logic        yc3;
	logic [1:0]  cent;
	logic [17:0] year_days;
	logic [8:0]  doy_s12;
	logic        leap_s12;
	logic [23:0] ybase_s12;
	logic [2:0]  wd_s12;
	tod_t        tod_s12;

	assign yc1       = yoe_s11 >= YOE_C1;
	assign yc2       = yoe_s11 >= YOE_C2;
	assign yc3       = yoe_s11 >= YOE_C3;
	assign cent      = 2'(yc1) + 2'(yc2) + 2'(yc3);
	assign year_days = 18'(yoe_s11) * 18'd365 + 18'(yoe_s11 >> 2) - 18'(cent);

	always_ff @(posedge clk) begin
		if (en[12]) begin
			doy_s12   <= 9'(doe_s11 - year_days);
			leap_s12  <= (yoe_s11[1:0] == 2'd0) && (yoe_s11 != YOE_C1)
				&& (yoe_s11 != YOE_C2) && (yoe_s11 != YOE_C3);
			ybase_s12 <= 24'(era_s11) * 24'd400 + 24'(yoe_s11) - YEAR_SUB;
			wd_s12    <= wd_s11;
			tod_s12   <= tod_s11;
		end
	end

	// s13: march-based month
	logic [10:0] mp_num;
	logic [22:0] prod_mp;
	logic [3:0]  mp_s13;
	logic [8:0]  doy_s13;
	logic        leap_s13;
	logic [23:0] ybase_s13;
	logic [2:0]  wd_s13;
	tod_t        tod_s13;

	assign mp_num  = 11'(doy_s12) * 11'd5 + 11'd2;
	assign prod_mp = 23'(mp_num) * 23'(M_MP);

	always_ff @(posedge clk) begin
		if (en[13]) begin
			mp_s13    <= prod_mp[S_MP +: 4];
			doy_s13   <= doy_s12;
			leap_s13  <= leap_s12;
			ybase_s13 <= ybase_s12;
			wd_s13    <= wd_s12;
			tod_s13   <= tod_s12;
		end
	end

	// s14: output register; january and february belong to the next year
	logic      jan_feb;
	ecal_out_t res_s14;

	assign jan_feb = mp_s13 >= MP_JAN;

	always_ff @(posedge clk) begin
		if (en[14]) begin
			res_s14.year_offset      <= $signed(ybase_s13 + 24'(jan_feb));
			res_s14.month_index      <= jan_feb ? mp_s13 - MP_JAN : mp_s13 + 4'd2;
			res_s14.day_of_month     <= 5'(doy_s13 - month_start(mp_s13) + 9'd1);
			res_s14.hour_of_day      <= tod_s13.hour;
			res_s14.minute_of_hour   <= tod_s13.minute;
			res_s14.second_of_minute <= tod_s13.second;
			res_s14.weekday          <= wd_s13;
			res_s14.day_of_year      <= jan_feb ? doy_s13 - JAN1_DOY
				: doy_s13 + MAR1_YDAY + 9'(leap_s13);
		end
	end

	assign calendar.valid = vld_q[NSTG];
	assign calendar.data  = res_s14;

endmodule

`default_nettype wire

// ===== hdl/ecal_checker.sv =====
`default_nettype none

module ecal_checker
	import ecal_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input ecal_out_t out_data
);

	logic [OCC_W-1:0] occ_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken in and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(in_acc) - OCC_W'(out_acc);
		end
	end

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// no result without an item in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("result without an item in flight");

	// every field but the year within its calendar range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.month_index <= MONTH_DEC) && (out_data.day_of_month != 5'd0)
			&& (out_data.hour_of_day <= 5'd23) && (out_data.minute_of_hour <= 6'd59)
			&& (out_data.second_of_minute <= 6'd59) && (out_data.weekday <= 3'd6)
			&& (out_data.day_of_year <= 9'd365))
		else $error("result field out of range");

	// in january the day of year follows the day of month
	a_january: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.month_index == MONTH_JAN)
			|-> out_data.day_of_year == 9'(out_data.day_of_month) - 9'd1)
		else $error("january day of year mismatch");

endmodule

bind epoch_seconds_to_utc_calendar ecal_checker u_ecal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (epoch.valid),
	.in_ready  (epoch.ready),
	.out_valid (calendar.valid),
	.out_ready (calendar.ready),
	.out_data  (calendar.data)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ecal_pkg::*;

	// scoreboard: predicts the calendar breakdown of each accepted timestamp
	class calendar_scoreboard;
		ecal_out_t expected_dates[$];
		int        failures;

		function new();
			failures = 0;
		endfunction

		static function longint floor_quot(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0)
				q = q - 1;
			return q;
		endfunction

		// day count of january 1 of a year, relative to the epoch
		static function longint jan1_days(longint year);
			longint y, era, yoe, doe;
			y   = year - 1;
			era = floor_quot(y, 400);
			yoe = y - era * 400;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
			return era * 146097 + doe - 719468;
		endfunction

		static function ecal_out_t civil_date_of(ecal_in_t item);
			ecal_out_t d;
			longint t, days, secs, z, era, doe, yoe, doy, mp, dom, mon, year, wd;
			t    = item.epoch_seconds;
			days = floor_quot(t, 86400);
			secs = t - days * 86400;
			z    = days + 719468;
			era  = floor_quot(z, 146097);
			doe  = z - era * 146097;
			yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp   = (5 * doy + 2) / 153;
			dom  = doy - (153 * mp + 2) / 5 + 1;
			mon  = (mp < 10) ? mp + 3 : mp - 9;
			year = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
			wd   = days - floor_quot(days, 7) * 7;
			wd   = (wd + 4) % 7;
			d.year_offset      = 24'(year - 1900);
			d.month_index      = 4'(mon - 1);
			d.day_of_month     = 5'(dom);
			d.hour_of_day      = 5'(secs / 3600);
			d.minute_of_hour   = 6'((secs / 60) % 60);
			d.second_of_minute = 6'(secs % 60);
			d.weekday          = 3'(wd);
			d.day_of_year      = 9'(days - jan1_days(year));
			return d;
		endfunction

		function void note_epoch(ecal_in_t item);
			expected_dates.push_back(civil_date_of(item));
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				failures++;
				$display("%0t %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_date(ecal_out_t got);
			ecal_out_t want;
			if (expected_dates.size() == 0) begin
				failures++;
				$display("%0t unexpected item expected none actual %h", $time, got);
				return;
			end
			want = expected_dates.pop_front();
			compare_field("year_offset", want.year_offset, got.year_offset);
			compare_field("month_index", want.month_index, got.month_index);
			compare_field("day_of_month", want.day_of_month, got.day_of_month);
			compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
			compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
			compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
			compare_field("weekday", want.weekday, got.weekday);
			compare_field("day_of_year", want.day_of_year, got.day_of_year);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ecal_stream_if #(.payload_t(ecal_in_t))  epoch_if ();
	ecal_stream_if #(.payload_t(ecal_out_t)) cal_if ();

	epoch_seconds_to_utc_calendar uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.epoch    (epoch_if.sink),
		.calendar (cal_if.source)
	);

	calendar_scoreboard sb;

	localparam longint SEC_MAX = 64'sd140737488355327;
	localparam longint SEC_MIN = -64'sd140737488355328;

	always #1 clk = ~clk;

	// send one timestamp, idling first unless in a burst
	task automatic send_epoch(input longint value, input bit burst);
		int unsigned gap;
		ecal_in_t    item;
		gap = burst ? 0 : $urandom_range(0, 14);
		item.epoch_seconds = 48'(value);
		repeat (gap) begin
			@(negedge clk);
			epoch_if.valid <= 1'b0;
		end
		@(negedge clk);
		epoch_if.valid <= 1'b1;
		epoch_if.data  <= item;
		do
			@(posedge clk);
		while (!epoch_if.ready);
		sb.note_epoch(item);
	endtask

	// random timestamp, weighted toward calendar boundaries
	function automatic longint random_epoch();
		longint v;
		longint yr;
		case ($urandom_range(0, 5))
			0: v = longint'(48'({$urandom, $urandom}));
			1: v = longint'(signed'($urandom));
			2: v = (longint'($urandom_range(0, 2097152)) - 1048576) * 86400
				+ longint'($urandom_range(0, 4)) - 2;
			3: begin
				if ($urandom_range(0, 1))
					v = SEC_MAX - longint'($urandom_range(0, 1048576));
				else
					v = SEC_MIN + longint'($urandom_range(0, 1048576));
			end
			4: v = ((longint'($urandom_range(0, 40)) - 20) * 146097 - 719468) * 86400
				+ longint'($urandom_range(0, 2 * 86400 * 400)) - 86400 * 400;
			default: begin
				yr = longint'($urandom_range(0, 8000)) - 3000;
				v  = calendar_scoreboard::jan1_days(yr) * 86400
					+ longint'($urandom_range(0, 2 * 86400)) - 86400;
			end
		endcase
		return v;
	endfunction

	// stimulus: directed corners, then random timestamps in bursts and gaps
	initial begin
		longint directed_epochs[$];
		bit     burst;
		sb = new();
		clk            = 1'b0;
		arst_n         = 1'b0;
		epoch_if.valid = 1'b0;
		epoch_if.data  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		directed_epochs = '{
			0, -1, 1, 86399, 86400, -86400, -86401,
			SEC_MAX, SEC_MIN,
			64'sd951782400,       // leap day in a leap century
			64'sd951868800,       // march 1 after it
			-64'sd2203891200,     // march 1 of a non-leap century
			-64'sd2203891201,     // last second of february that year
			64'sd1483228799,      // last second of a leap year
			64'sd1483228800,      // new year after it
			-64'sd62162035200,    // start of an era
			-64'sd62162035201,    // last second of the previous era
			-64'sd62167219200,    // january 1 of year zero
			64'sd13574563200,     // leap day far ahead
			64'sd1700000000,
			-64'sd1000000000000,
			64'sd1000000000000
		};
		foreach (directed_epochs[i])
			send_epoch(directed_epochs[i], 1'b0);

		burst = 1'b0;
		for (int n = 0; n < 1200; n++) begin
			if (n % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			send_epoch(random_epoch(), burst);
		end
		@(negedge clk);
		epoch_if.valid <= 1'b0;

		while (sb.expected_dates.size() != 0)
			@(posedge clk);
		repeat (NSTG + 6) @(posedge clk);
		if (sb.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls with stretches of none
	initial begin
		int unsigned stall;
		int          count;
		bit          burst;
		cal_if.ready = 1'b0;
		count = 0;
		burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if (count % 40 == 0)
				burst = ($urandom_range(0, 3) == 0);
			count++;
			stall = burst ? 0 : $urandom_range(0, 14);
			repeat (stall) begin
				@(negedge clk);
				cal_if.ready <= 1'b0;
			end
			@(negedge clk);
			cal_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!cal_if.valid);
			sb.check_date(cal_if.data);
		end
	end

	// watchdog
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ecal_pkg.sv
hdl/ecal_stream_if.sv
hdl/epoch_seconds_to_utc_calendar.sv
hdl/ecal_checker.sv
verif/tb.sv
